[sv/assert_macros.svh]
// Assertion macros for the RTL files (included by frgcd_ctrl).
// The including module must have a clock named clk and an active-low reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

[sv/frgcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frgcd_pkg
// Widths and controller/datapath interface types for the fraction reducer.
// ----------------------------------------------------------------------------
package frgcd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int SHIFT_W    = $clog2(DATA_WIDTH);
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic gcd_latch;
		logic div_start_num;
		logic div_start_den;
		logic div_step;
		logic wb_num;
		logic wb_den;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic both_pos;
		logic gcd_done;
		logic div_done;
	} dp_stat_t;

endpackage

[sv/fraction_reduce_by_gcd_core.sv]
`timescale 1ns / 1ps
// A fraction that is not strictly positive on both sides skips the GCD and divisions:
// it is loaded and goes to the output register once that register is free. Otherwise
// the binary GCD loop runs, then two restoring divisions share one subtractor.
// The core takes one fraction at a time; in_ready is high only while idle.
// Reset (arst_n, asynchronous) returns the controller to idle with no result pending.
// ----------------------------------------------------------------------------
// fraction_reduce_by_gcd_core
// Reduces a signed fraction to lowest terms when both parts are positive; else passes it through.
// ----------------------------------------------------------------------------
module fraction_reduce_by_gcd_core
	import frgcd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] numerator,
	input  logic signed [DATA_WIDTH-1:0] denominator,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] reduced_numerator,
	output logic signed [DATA_WIDTH-1:0] reduced_denominator
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	frgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	frgcd_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.numerator           (numerator),
		.denominator         (denominator),
		.reduced_numerator   (reduced_numerator),
		.reduced_denominator (reduced_denominator)
	);

endmodule

[sv/frgcd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frgcd_dp
// Datapath: binary GCD unit, shared restoring divider and output register.
// ----------------------------------------------------------------------------
module frgcd_dp
	import frgcd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_stat_t                     stat,
	input  logic signed [DATA_WIDTH-1:0] numerator,
	input  logic signed [DATA_WIDTH-1:0] denominator,
	output logic signed [DATA_WIDTH-1:0] reduced_numerator,
	output logic signed [DATA_WIDTH-1:0] reduced_denominator
);

	data_t              num_in;
	data_t              den_in;
	data_t              n_q;
	data_t              d_q;
	data_t              a_q;
	data_t              b_q;
	logic [SHIFT_W-1:0] k_q;
	data_t              g_q;
	data_t              rem_q;
	data_t              dvd_q;
	logic [CNT_W-1:0]   cnt_q;
	data_t              diff_ab;
	data_t              diff_ba;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH+1:0] sub;
	logic               fit;

	assign num_in = data_t'($unsigned(numerator));
	assign den_in = data_t'($unsigned(denominator));

	assign stat.both_pos = (num_in != '0) && !num_in[DATA_WIDTH-1] &&
		(den_in != '0) && !den_in[DATA_WIDTH-1];
	assign stat.gcd_done = (a_q == b_q);
	assign stat.div_done = (cnt_q == '0);

	assign diff_ab = a_q - b_q;
	assign diff_ba = b_q - a_q;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, dvd_q[DATA_WIDTH-1]};
	assign sub   = {1'b0, trial} - {2'b00, g_q};
	assign fit   = !sub[DATA_WIDTH+1];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= num_in;
			d_q <= den_in;
			a_q <= num_in;
			b_q <= den_in;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			// Stein's method: strip common twos, strip single twos, subtract odd pairs.
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= diff_ab;
			end else begin
				b_q <= diff_ba;
			end
		end
		if (cmd.gcd_latch) begin
			g_q <= a_q << k_q;
		end
		if (cmd.div_start_num || cmd.div_start_den) begin
			rem_q <= '0;
			dvd_q <= cmd.div_start_num ? n_q : d_q;
		end else if (cmd.div_step) begin
			rem_q <= fit ? sub[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], fit};
		end
		if (cmd.wb_num) begin
			n_q <= dvd_q;
		end
		if (cmd.wb_den) begin
			d_q <= dvd_q;
		end
		if (cmd.out_load) begin
			reduced_numerator   <= $signed(n_q);
			reduced_denominator <= $signed(d_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start_num || cmd.div_start_den) begin
			cnt_q <= CNT_W'(DATA_WIDTH);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[sv/frgcd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frgcd_ctrl
// Controller: sequences load, GCD loop, two divisions and the output beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frgcd_ctrl
	import frgcd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_DIV_NUM,
		S_DIV_DEN,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.both_pos ? S_GCD : S_FINISH;
				end
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					cmd.gcd_latch     = 1'b1;
					cmd.div_start_num = 1'b1;
					state_d           = S_DIV_NUM;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIV_NUM: begin
				if (stat.div_done) begin
					cmd.wb_num        = 1'b1;
					cmd.div_start_den = 1'b1;
					state_d           = S_DIV_DEN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DIV_DEN: begin
				if (stat.div_done) begin
					cmd.wb_den = 1'b1;
					state_d    = S_FINISH;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FINISH: begin
				// The output register is free once its beat is gone or leaves now.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_valid_q && !out_ready)
	`ASSERT_NEVER(a_step_past_end, cmd.div_step && stat.div_done)
	`ASSERT_AT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
	`ASSERT_AT(a_bypass, (in_valid && in_ready && !stat.both_pos) |=> (state_q == S_FINISH))

endmodule
